>>> src/ssp_pkg.sv
// Shared types and constants for the sorted set predecessor block.
// This file has no dependencies. Every module of the block imports it.
package ssp_pkg;

  localparam int unsigned ValW = 64;
  localparam int unsigned OpW  = 2;
  localparam int unsigned CntW = 7;

  localparam logic [OpW-1:0] OP_INSERT = 2'd0;
  localparam logic [OpW-1:0] OP_DELETE = 2'd1;
  localparam logic [OpW-1:0] OP_QUERY  = 2'd2;

  typedef logic signed [ValW-1:0] val_t;

  // These are the per-cycle commands that are broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
  } ssp_ctl_t;

endpackage

>>> src/ssp_cell.sv
// One cell of the sorted chain. It holds one entry and its registered compare flags.
// It depends on ssp_pkg.
module ssp_cell
  import ssp_pkg::*;
(
  input  logic     clk,
  input  ssp_ctl_t ctl,
  input  logic     occ,
  input  val_t     key,
  input  logic     left_lt,
  input  val_t     left_val,
  input  val_t     right_val,
  output val_t     val,
  output logic     lt,
  output logic     eq
);

  val_t val_r;
  logic lt_r;
  logic eq_r;

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt_r <= occ & (val_r < key);
      eq_r <= occ & (val_r == key);
    end
    if (ctl.ins_en && !lt_r) begin
      val_r <= left_lt ? key : left_val;
    end else if (ctl.del_en && !lt_r) begin
      val_r <= right_val;
    end
  end

  assign val = val_r;
  assign lt  = lt_r;
  assign eq  = eq_r;

endmodule

>>> src/sorted_set_predecessor.sv
// Top level of the sorted set predecessor block: control, fill count and result register.
// It depends on ssp_pkg and ssp_cell.
//
// The block keeps up to CAPACITY distinct signed 64-bit values in ascending order, one value
// to a cell of a chain. An input transaction carries an opcode (insert, delete or predecessor
// query) and a value; every input transaction gives exactly one output transaction with the
// found flag, the predecessor value, the dropped flag and the count after the operation.
// An item is taken in the idle state and compared against all cells in parallel in the compare
// step (ST_CMP). In the update step (ST_UPD) the chain shifts by one place and the result is
// written to the output register, which raises output valid. The block takes no new item
// until the update step is done; the single compare-then-shift pass sets this.
// The output register lets a new item be taken while a result still waits. If the receiver
// stalls, the item behind it waits in its final step until the output register is free.
// A synchronous reset empties the set at once by clearing the fill count; cell contents are
// not cleared, since only cells below the count are ever compared.
module sorted_set_predecessor
  import ssp_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OpW-1:0]        in_opcode,
  input  logic signed [ValW-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic signed [ValW-1:0] out_pred_value,
  output logic                  out_dropped,
  output logic [CntW-1:0]       out_stored_count
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  state_t         state_r;
  logic [OpW-1:0] op_r;
  val_t           key_r;
  logic [CW-1:0]  count_r;
  logic           out_valid_r;
  logic           found_r;
  val_t           pred_r;
  logic           dropped_r;

  ssp_ctl_t          ctl;
  logic [CAPACITY-1:0] occ_vec;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY:0]   le_vec;
  val_t                cell_val [CAPACITY];
  val_t                pred_sel;
  logic                present;
  logic                full;
  logic                advance;
  logic                do_ins;
  logic                do_del;
  logic                do_drop;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ_vec[i] = count_r > CW'(i);
    ssp_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ_vec[i]),
      .key       (key_r),
      .left_lt   ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i-1]),
      .left_val  (cell_val[(i == 0) ? 0 : i-1]),
      .right_val (cell_val[(i == CAPACITY-1) ? i : i+1]),
      .val       (cell_val[i]),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i])
    );
  end

  assign le_vec  = {1'b0, lt_vec | eq_vec};
  assign present = |eq_vec;
  assign full    = count_r == CW'(CAPACITY);
  assign advance = (state_r == ST_UPD) && (!out_valid_r || out_ready);
  assign do_ins  = advance && (op_r == OP_INSERT) && !present && !full;
  assign do_del  = advance && (op_r == OP_DELETE) && present;
  assign do_drop = (op_r == OP_INSERT) && !present && full;

  assign ctl.cmp_en = state_r == ST_CMP;
  assign ctl.ins_en = do_ins;
  assign ctl.del_en = do_del;

  always_comb begin
    pred_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (le_vec[i] && !le_vec[i+1]) begin
        pred_sel = pred_sel | cell_val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r    <= in_opcode;
            key_r   <= in_value;
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (advance) begin
            found_r     <= (op_r == OP_QUERY) && le_vec[0];
            pred_r      <= ((op_r == OP_QUERY) && le_vec[0]) ? pred_sel : '0;
            dropped_r   <= do_drop;
            if (do_ins) begin
              count_r <= count_r + CW'(1);
            end else if (do_del) begin
              count_r <= count_r - CW'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready         = rst_n && (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_found        = found_r;
  assign out_pred_value   = pred_r;
  assign out_dropped      = dropped_r;
  assign out_stored_count = CntW'(count_r);

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_lt_thermo : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot({1'b0, lt_vec} + {{CAPACITY{1'b0}}, 1'b1}))
    else $error("less-than flags are not a prefix of the chain");

  a_eq_single : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_UPD))
    else $error("result raised outside the update step");

  a_drop_full : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && do_drop) |=> (count_r == CW'(CAPACITY)))
    else $error("insert dropped while the store was not full");

endmodule

>>> tb/ssp_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the sorted set predecessor testbench: a behavioural copy of the ordered set
// that predicts each output transaction, and the checker for the block's outputs.
// It depends on ssp_pkg.
package ssp_tb_pkg;
  import ssp_pkg::*;

  localparam logic [OpW-1:0] OP_NOP = 2'd3;

  typedef struct {
    logic                found;
    val_t                pred_value;
    logic                dropped;
    logic [CntW-1:0]     stored_count;
  } set_result_t;

  class predecessor_scoreboard;
    val_t        held_values[];
    int unsigned fill;
    int unsigned capacity;
    set_result_t expected_results[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned inserts;
    int unsigned deletes;
    int unsigned queries;
    int unsigned refusals;
    int unsigned peak_fill;

    function new(int unsigned cap);
      capacity    = cap;
      held_values = new[cap];
      fill        = 0;
      errors      = 0;
      checked     = 0;
      inserts     = 0;
      deletes     = 0;
      queries     = 0;
      refusals    = 0;
      peak_fill   = 0;
    endfunction

    function void apply_operation(logic [OpW-1:0] op, val_t value);
      set_result_t r;
      int unsigned pos;
      int unsigned idx;
      int unsigned i;
      bit          present;
      r.found        = 1'b0;
      r.pred_value   = '0;
      r.dropped      = 1'b0;
      r.stored_count = '0;
      pos = 0;
      for (i = 0; i < fill; i++) begin
        if (held_values[i] < value) pos++;
      end
      present = (pos < fill) && (held_values[pos] == value);
      case (op)
        OP_INSERT: begin
          inserts++;
          if (!present) begin
            if (fill >= capacity) begin
              r.dropped = 1'b1;
              refusals++;
            end else begin
              for (i = fill; i > pos; i--) held_values[i] = held_values[i-1];
              held_values[pos] = value;
              fill++;
            end
          end
        end
        OP_DELETE: begin
          deletes++;
          if (present) begin
            for (i = pos; i + 1 < fill; i++) held_values[i] = held_values[i+1];
            fill--;
          end
        end
        OP_QUERY: begin
          queries++;
          idx = present ? pos + 1 : pos;
          if (idx > 0) begin
            r.found      = 1'b1;
            r.pred_value = held_values[idx-1];
          end
        end
        default: ;
      endcase
      if (fill > peak_fill) peak_fill = fill;
      r.stored_count = CntW'(fill);
      expected_results.push_back(r);
    endfunction

    function void check_result(logic found, val_t pred_value, logic dropped,
                               logic [CntW-1:0] stored_count);
      set_result_t e;
      if (expected_results.size() == 0) begin
        $error("output transaction arrived with nothing expected");
        errors++;
        return;
      end
      e = expected_results.pop_front();
      checked++;
      if (found !== e.found) begin
        $error("found: expected %0d, actual %0d", e.found, found);
        errors++;
      end
      if (pred_value !== e.pred_value) begin
        $error("pred_value: expected %0d, actual %0d", e.pred_value, pred_value);
        errors++;
      end
      if (dropped !== e.dropped) begin
        $error("dropped: expected %0d, actual %0d", e.dropped, dropped);
        errors++;
      end
      if (stored_count !== e.stored_count) begin
        $error("stored_count: expected %0d, actual %0d", e.stored_count, stored_count);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/tb_sorted_set_predecessor.sv
`timescale 1ns / 100ps
// Top level of the sorted set predecessor testbench: clock, reset, stimulus and output monitor.
// It depends on ssp_pkg, ssp_tb_pkg and the sorted_set_predecessor RTL.
module tb_sorted_set_predecessor;
  import ssp_pkg::*;
  import ssp_tb_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned POOL_SIZE = 96;
  localparam val_t VAL_MIN = {1'b1, {(ValW-1){1'b0}}};
  localparam val_t VAL_MAX = {1'b0, {(ValW-1){1'b1}}};

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  logic [OpW-1:0]  in_opcode;
  val_t            in_value;
  logic            out_valid;
  logic            out_ready;
  logic            out_found;
  val_t            out_pred_value;
  logic            out_dropped;
  logic [CntW-1:0] out_stored_count;

  predecessor_scoreboard board;
  bit                    quiet;
  val_t                  value_pool[POOL_SIZE];

  sorted_set_predecessor #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_pred_value  (out_pred_value),
    .out_dropped     (out_dropped),
    .out_stored_count(out_stored_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("sorted_set_predecessor regression: fail");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic val_t pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return value_pool[$urandom_range(0, POOL_SIZE-1)];
    if (roll < 95) return {$urandom, $urandom};
    return value_pool[$urandom_range(0, POOL_SIZE-1)] + ($urandom_range(0, 1) ? 1 : -1);
  endfunction

  function automatic logic [OpW-1:0] pick_opcode(int unsigned ins_pct, int unsigned del_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return OP_NOP;
    if (roll < 2 + ins_pct) return OP_INSERT;
    if (roll < 2 + ins_pct + del_pct) return OP_DELETE;
    return OP_QUERY;
  endfunction

  task automatic send_item(input logic [OpW-1:0] op, input val_t value);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.apply_operation(op, value);
  endtask

  task automatic run_phase(input int unsigned items, input int unsigned ins_pct,
                           input int unsigned del_pct);
    int unsigned n;
    for (n = 0; n < items; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_item(pick_opcode(ins_pct, del_pct), pick_value());
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_found, out_pred_value, out_dropped, out_stored_count);
    end
  end

  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    int unsigned i;
    int unsigned waited;
    board     = new(CAPACITY);
    quiet     = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_opcode <= OP_INSERT;
    in_value  <= '0;

    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = '0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    value_pool[5] = VAL_MIN + 1;
    value_pool[6] = VAL_MAX - 1;
    value_pool[7] = 64'h5555_5555_5555_5555;
    for (i = 8; i < 40; i++) value_pool[i] = val_t'($signed($urandom_range(0, 200)) - 100);
    for (i = 40; i < POOL_SIZE; i++) value_pool[i] = {$urandom, $urandom};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_item(OP_QUERY, '0);
    send_item(OP_DELETE, VAL_MAX);
    send_item(OP_NOP, '0);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, VAL_MIN);
    send_item(OP_INSERT, VAL_MAX);
    send_item(OP_INSERT, '0);
    send_item(OP_QUERY, VAL_MIN);
    send_item(OP_QUERY, VAL_MAX);
    send_item(OP_QUERY, -1);
    send_item(OP_QUERY, 1);
    send_item(OP_QUERY, VAL_MAX - 1);
    send_item(OP_DELETE, VAL_MIN);
    send_item(OP_QUERY, VAL_MIN);
    send_item(OP_QUERY, -5);
    send_item(OP_DELETE, 7);
    send_item(OP_INSERT, -1);
    send_item(OP_INSERT, 64'h5555_5555_5555_5555);
    send_item(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_QUERY, 64'hAAAA_AAAA_AAAA_AAAB);
    send_item(OP_NOP, 64'hFFFF_0000_FFFF_0000);
    send_item(OP_DELETE, VAL_MAX);
    send_item(OP_DELETE, '0);
    send_item(OP_QUERY, VAL_MAX);

    run_phase(160, 75, 10);
    run_phase(120, 40, 30);
    run_phase(150, 15, 60);
    run_phase(120, 35, 25);

    in_valid <= 1'b0;
    waited = 0;
    while (board.expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (board.expected_results.size() != 0) begin
      $error("%0d expected output transactions never arrived", board.expected_results.size());
      board.errors++;
    end

    $display("Checked %0d output transactions: %0d inserts (%0d refused on a full set),",
             board.checked, board.inserts, board.refusals);
    $display("%0d deletes and %0d queries; the set peaked at %0d of %0d entries.",
             board.deletes, board.queries, board.peak_fill, CAPACITY);
    $display("%0d mismatches were seen.", board.errors);
    if (board.errors == 0) begin
      $display("sorted_set_predecessor regression: pass");
    end else begin
      $display("sorted_set_predecessor regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
src/ssp_pkg.sv
src/ssp_cell.sv
src/sorted_set_predecessor.sv
tb/ssp_tb_pkg.sv
tb/tb_sorted_set_predecessor.sv
